>>> hdl/cdfs_pkg.sv
// cdfs_pkg: shared types and constants for the CDF table sampler.
// Holds the controller state enum, the command and status structs, the table depth and
// the fixed field widths. No dependencies.
package cdfs_pkg;

  localparam int unsigned TABLE_DEPTH = 128; // table entries, matches the 7-bit index
  localparam int unsigned IDX_W  = 7;   // entry_index and sample_index width
  localparam int unsigned SIZE_W = 8;   // table_size register width

  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd100;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_wr;  // write one table entry from the input transfer
    logic start;    // open a search and issue the first probe
    logic step;     // narrow the interval and issue the next probe
    logic emit;     // move the search result into the output register
  } cmd_t;

  typedef struct packed {
    logic search_last;  // the interval closes with this step
  } status_t;

endpackage

>>> hdl/cdf_table_sampler_core.sv
// cdf_table_sampler_core: top level of the discrete inverse-transform sampler.
// Instantiates cdfs_ctrl and cdfs_datapath; depends on cdfs_pkg.
//
//   channel   ports                                   handshake
//   --------  --------------------------------------  -----------------------
//   input     in_func, in_entry_index, in_entry_value, in_valid / in_ready
//             in_uniform_sample
//   result    out_sample_index, out_above_table        out_valid / out_ready
//   config    cfg_wdata (table_size)                  cfg_we, no wait
//
// A load transfer writes one table entry; it gives no result.
// A sample transfer searches the first n entries, n the table size in use: one
// probe of the single read port per cycle, the next probe address formed from
// the compare on the data just read.
// A finished result moves into the output register, which holds while out_ready
// is low; the next item is taken meanwhile, and only the hand-off of the next
// result waits. Reset (rst_n, synchronous) sets table_size to 100 and leaves the
// table contents undefined until loaded.
module cdf_table_sampler_core #(
  parameter int unsigned PROB_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [cdfs_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [PROB_BITS:0]            in_entry_value,
  input  logic [PROB_BITS-1:0]          in_uniform_sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cdfs_pkg::IDX_W-1:0]    out_sample_index,
  output logic                          out_above_table,
  // configuration
  input  logic                          cfg_we,
  input  logic [cdfs_pkg::SIZE_W-1:0]   cfg_wdata
);
  import cdfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequence each transfer: load, search, hand off
  cdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // table memory, binary search interval and result register
  cdfs_datapath #(
    .PROB_BITS   (PROB_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .in_uniform_sample (in_uniform_sample),
    .cmd               (cmd),
    .status            (status),
    .out_sample_index  (out_sample_index),
    .out_above_table   (out_above_table)
  );

endmodule

>>> hdl/cdfs_ctrl.sv
// cdfs_ctrl: controller state machine for the CDF table sampler.
// Sequences load, search and result hand-off; owns the output valid flag.
// Depends on cdfs_pkg.
module cdfs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_func,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cdfs_pkg::cmd_t   cmd,
  input  cdfs_pkg::status_t status
);
  import cdfs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func == FUNC_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.search_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/cdfs_datapath.sv
// cdfs_datapath: table memory, search interval registers and result register.
// Also holds the table_size configuration register.
// Depends on cdfs_pkg.
module cdfs_datapath #(
  parameter int unsigned PROB_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cdfs_pkg::SIZE_W-1:0]   cfg_wdata,
  input  logic [cdfs_pkg::IDX_W-1:0]    in_entry_index,
  input  logic [PROB_BITS:0]            in_entry_value,
  input  logic [PROB_BITS-1:0]          in_uniform_sample,
  input  cdfs_pkg::cmd_t                cmd,
  output cdfs_pkg::status_t             status,
  output logic [cdfs_pkg::IDX_W-1:0]    out_sample_index,
  output logic                          out_above_table
);
  import cdfs_pkg::*;

  localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

  logic [PROB_BITS:0]   mem [TABLE_DEPTH];
  logic [PROB_BITS:0]   rd_data_r;

  logic [SIZE_W-1:0]    table_size_r;
  logic [SIZE_W-1:0]    n_use;
  logic [PROB_BITS-1:0] u_r;
  logic [SIZE_W-1:0]    lo_r, hi_r, mid_r;
  logic [SIZE_W-1:0]    lo_nxt, hi_nxt, lo_sel, hi_sel, mid_sel;
  logic [SIZE_W:0]      mid_sum;
  logic                 greater;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic                 rd_en;
  logic                 above;
  logic [IDX_W-1:0]     sample_index_r;
  logic                 above_table_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // clamp the size in use to 1..TABLE_DEPTH
  always_comb begin
    if (table_size_r == '0) begin
      n_use = SIZE_W'(1);
    end else if (32'(table_size_r) > TABLE_DEPTH) begin
      n_use = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_use = table_size_r;
    end
  end

  // interval update from the probe that just returned
  assign greater = rd_data_r > {1'b0, u_r};
  assign lo_nxt  = greater ? lo_r : mid_r + SIZE_W'(1);
  assign hi_nxt  = greater ? mid_r : hi_r;
  assign status.search_last = lo_nxt >= hi_nxt;

  assign lo_sel  = cmd.start ? '0 : lo_nxt;
  assign hi_sel  = cmd.start ? n_use : hi_nxt;
  assign mid_sum = {1'b0, lo_sel} + {1'b0, hi_sel};
  assign mid_sel = mid_sum[SIZE_W:1];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      u_r <= in_uniform_sample;
    end
    if (cmd.start || cmd.step) begin
      lo_r  <= lo_sel;
      hi_r  <= hi_sel;
      mid_r <= mid_sel;
    end
  end

  // table memory: one write port for loads, one registered read port for probes
  assign wr_en   = cmd.load_wr && (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = ADDR_W'(in_entry_index);
  assign rd_en   = cmd.start || cmd.step;
  assign rd_addr = ADDR_W'(mid_sel);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // result: saturate to the last entry in use when nothing exceeded the value
  assign above = lo_r >= n_use;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_index_r <= above ? IDX_W'(n_use - SIZE_W'(1)) : IDX_W'(lo_r);
      above_table_r  <= above;
    end
  end

  assign out_sample_index = sample_index_r;
  assign out_above_table  = above_table_r;

endmodule
